### design/sliding_window_min_max_with_index_unit_assert.svh
// sliding_window_min_max_with_index_unit_assert.svh: assertion macros for the envelope unit.
// Expects clk and rst_n in the scope of use; the macros expand to nothing under SYNTHESIS.
`ifndef SLIDING_WINDOW_MIN_MAX_WITH_INDEX_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MIN_MAX_WITH_INDEX_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SWMM_ASSERT_IMPLY(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
// next-cycle implication
`define SWMM_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define SWMM_ASSERT_IMPLY(label, cond, expr, msg)
`define SWMM_ASSERT_NEXT(label, cond, expr, msg)
`endif
`endif

### design/swmm_pkg.sv
`timescale 1ns / 1ps
// swmm_pkg.sv: types and fixed constants of the sliding-window min/max unit.
// No dependencies; every module of the unit but swmm_ram refers to it by scoped names.
package swmm_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int POS_BITS    = 16;
    localparam int RADIUS_BITS = 6;
    localparam int PEND_BITS   = 7;
    localparam int LIMIT_BITS  = 7;
    localparam int MAX_RADIUS  = 63;

    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 6'd1;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] sample;
        logic                         last_sample;
    } sample_beat_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] lower_value;
        logic [POS_BITS-1:0]          lower_position;
        logic signed [VALUE_BITS-1:0] upper_value;
        logic [POS_BITS-1:0]          upper_position;
        logic                         final_result;
    } result_beat_t;

    // one classified sample, front to back
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [POS_BITS-1:0]          pos;
        logic                         last;
        logic [RADIUS_BITS-1:0]       radius;
        logic [PEND_BITS-1:0]         pend;
        logic [RADIUS_BITS-1:0]       keep;
    } job_t;

    typedef struct packed {
        logic                         push;
        logic                         front;
        logic                         clear;
        logic signed [VALUE_BITS-1:0] value;
        logic [POS_BITS-1:0]          pos;
        logic [LIMIT_BITS-1:0]        limit;
    } dq_cmd_t;

    typedef struct packed {
        logic                         busy;
        logic signed [VALUE_BITS-1:0] value;
        logic [POS_BITS-1:0]          pos;
    } dq_stat_t;

    typedef enum logic [1:0] {
        DQ_IDLE,
        DQ_PUSH,
        DQ_FRONT
    } dq_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PUSH,
        BK_FRONT
    } back_state_t;

endpackage

### design/swmm_ram.sv
`timescale 1ns / 1ps
// swmm_ram.sv: generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module swmm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/swmm_front.sv
`timescale 1ns / 1ps
// swmm_front.sv: input side; holds the radius register, numbers samples and
// works out how many envelope points each sample releases. Uses swmm_pkg.
module swmm_front #(
    parameter int DEQUE_DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   radius_wr_en,
    input  logic [swmm_pkg::RADIUS_BITS-1:0]       radius_wr_data,
    input  logic                                   sample_valid,
    output logic                                   sample_ready,
    input  swmm_pkg::sample_beat_t                 sample_beat,
    input  logic                                   job_full,
    output logic                                   job_push,
    output swmm_pkg::job_t                         job
);

    localparam int RB = swmm_pkg::RADIUS_BITS;
    localparam int PB = swmm_pkg::PEND_BITS;
    localparam int QB = swmm_pkg::POS_BITS;
    localparam int DEPTH_CAP  = (DEQUE_DEPTH - 2) / 2;
    localparam int RADIUS_CAP = (swmm_pkg::MAX_RADIUS < DEPTH_CAP) ?
                                swmm_pkg::MAX_RADIUS : DEPTH_CAP;
    localparam logic [RB-1:0] CAP = RB'(RADIUS_CAP);

    logic [RB-1:0] radius_reg;
    logic [RB-1:0] pending_reg, pending_next;
    logic [QB-1:0] count_reg, count_next;
    logic [RB-1:0] r_eff;
    logic [PB-1:0] pend_new;
    logic          accept;

    assign sample_ready = !job_full;
    assign accept       = sample_valid && sample_ready;
    assign job_push     = accept;

    assign r_eff    = (radius_reg > CAP) ? CAP : radius_reg;
    assign pend_new = PB'(pending_reg) + PB'(1);

    always_comb
    begin
        job.value  = sample_beat.sample;
        job.pos    = count_reg;
        job.last   = sample_beat.last_sample;
        job.radius = r_eff;
        job.pend   = pend_new;
        job.keep   = sample_beat.last_sample ? '0 : r_eff;
    end

    always_comb
    begin
        pending_next = pending_reg;
        count_next   = count_reg;
        if (accept)
        begin
            if (sample_beat.last_sample)
            begin
                pending_next = '0;
                count_next   = '0;
            end
            else
            begin
                // outputs run down to r still waiting
                pending_next = (pend_new > PB'(r_eff)) ? r_eff : RB'(pend_new);
                count_next   = count_reg + QB'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= swmm_pkg::RADIUS_RESET;
            pending_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (radius_wr_en)
            begin
                radius_reg <= radius_wr_data;
            end
            pending_reg <= pending_next;
            count_reg   <= count_next;
        end
    end

endmodule

### design/swmm_queue.sv
`timescale 1ns / 1ps
// swmm_queue.sv: two-entry queue of classified samples between front and back.
// Uses swmm_pkg for the entry type.
module swmm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  swmm_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output swmm_pkg::job_t head
);

    localparam int DEPTH     = 2;
    localparam int PTR_BITS  = $clog2(DEPTH);
    localparam int FILL_BITS = $clog2(DEPTH + 1);

    swmm_pkg::job_t       slot_reg [DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FILL_BITS-1:0] fill_reg, fill_next;

    assign full       = (fill_reg == FILL_BITS'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + FILL_BITS'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FILL_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            fill_reg <= fill_next;
        end
    end

endmodule

### design/swmm_deque.sv
`timescale 1ns / 1ps
// swmm_deque.sv: one monotonic deque of value/position pairs in a circular RAM.
// Keeps the minimum at the head; a max deque is fed inverted values. Uses swmm_pkg, swmm_ram.
module swmm_deque #(
    parameter int DEPTH = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  swmm_pkg::dq_cmd_t  cmd,
    output swmm_pkg::dq_stat_t stat
);

    localparam int VB = swmm_pkg::VALUE_BITS;
    localparam int QB = swmm_pkg::POS_BITS;
    localparam int LB = swmm_pkg::LIMIT_BITS;
    localparam int EW = VB + QB;
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = IW + 1;
    localparam logic [CW-1:0] FULL    = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

    function automatic logic [IW-1:0] wrap_index(input logic [SW-1:0] x);
        logic [SW-1:0] y;
        y = (x >= DEPTH_S) ? x - DEPTH_S : x;
        return y[IW-1:0];
    endfunction

    swmm_pkg::dq_state_t state_reg, state_next;
    logic [IW-1:0]       head_reg, head_next;
    logic [CW-1:0]       count_reg, count_next;
    logic signed [VB-1:0] val_reg;
    logic [QB-1:0]       pos_reg;
    logic [LB-1:0]       limit_reg;
    logic signed [VB-1:0] res_value_reg;
    logic [QB-1:0]       res_pos_reg;

    logic                wr_en;
    logic [IW-1:0]       wr_addr, rd_addr;
    logic [EW-1:0]       wr_data, rd_data;
    logic signed [VB-1:0] rd_value;
    logic [QB-1:0]       rd_pos, gap;
    logic [IW-1:0]       tail_addr, below_tail_addr, insert_addr, head_plus_one;
    logic                dominated, expired, res_load;

    swmm_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_value = rd_data[EW-1 -: VB];
    assign rd_pos   = rd_data[QB-1:0];

    assign tail_addr       = wrap_index(SW'(head_reg) + SW'(count_reg) - SW'(1));
    assign below_tail_addr = wrap_index(SW'(head_reg) + SW'(count_reg) - SW'(2));
    assign insert_addr     = wrap_index(SW'(head_reg) + SW'(count_reg));
    assign head_plus_one   = wrap_index(SW'(head_reg) + SW'(1));

    // newer value no greater: the older entry can never be the minimum again
    assign dominated = (rd_value >= val_reg);
    assign gap       = pos_reg - rd_pos;
    assign expired   = (count_reg > ONE_C) && (gap > QB'(limit_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swmm_pkg::DQ_IDLE:
            begin
                if (cmd.clear)
                begin
                    state_next = swmm_pkg::DQ_IDLE;
                end
                else if (cmd.push && (count_reg != '0))
                begin
                    state_next = swmm_pkg::DQ_PUSH;
                end
                else if (cmd.front)
                begin
                    state_next = swmm_pkg::DQ_FRONT;
                end
            end
            swmm_pkg::DQ_PUSH:
            begin
                if (!(dominated && (count_reg > ONE_C)))
                begin
                    state_next = swmm_pkg::DQ_IDLE;
                end
            end
            swmm_pkg::DQ_FRONT:
            begin
                if (!expired)
                begin
                    state_next = swmm_pkg::DQ_IDLE;
                end
            end
            default:
            begin
                state_next = swmm_pkg::DQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        rd_addr    = head_reg;
        wr_en      = 1'b0;
        wr_addr    = insert_addr;
        wr_data    = {val_reg, pos_reg};
        res_load   = 1'b0;
        unique case (state_reg)
            swmm_pkg::DQ_IDLE:
            begin
                if (cmd.clear)
                begin
                    head_next  = '0;
                    count_next = '0;
                end
                else if (cmd.push)
                begin
                    rd_addr = tail_addr;
                    if (count_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = head_reg;
                        wr_data    = {cmd.value, cmd.pos};
                        count_next = ONE_C;
                    end
                end
            end
            swmm_pkg::DQ_PUSH:
            begin
                rd_addr = below_tail_addr;
                if (dominated)
                begin
                    if (count_reg > ONE_C)
                    begin
                        count_next = count_reg - ONE_C;
                    end
                    else
                    begin
                        // last entry goes: new one takes its slot
                        wr_en   = 1'b1;
                        wr_addr = tail_addr;
                    end
                end
                else
                begin
                    wr_en = 1'b1;
                    if (count_reg == FULL)
                    begin
                        head_next = head_plus_one;
                    end
                    else
                    begin
                        count_next = count_reg + ONE_C;
                    end
                end
            end
            swmm_pkg::DQ_FRONT:
            begin
                rd_addr = head_plus_one;
                if (expired)
                begin
                    head_next  = head_plus_one;
                    count_next = count_reg - ONE_C;
                end
                else
                begin
                    res_load = 1'b1;
                end
            end
            default:
            begin
                rd_addr = head_reg;
            end
        endcase
    end

    always_comb
    begin
        stat.busy  = (state_reg != swmm_pkg::DQ_IDLE);
        stat.value = res_value_reg;
        stat.pos   = res_pos_reg;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == swmm_pkg::DQ_IDLE) && (cmd.push || cmd.front))
        begin
            val_reg   <= cmd.value;
            pos_reg   <= cmd.pos;
            limit_reg <= cmd.limit;
        end
        if (res_load)
        begin
            res_value_reg <= rd_value;
            res_pos_reg   <= rd_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swmm_pkg::DQ_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

endmodule

### design/swmm_back.sv
`timescale 1ns / 1ps
// swmm_back.sv: sequencer driving both deques and the result output register.
// Uses swmm_pkg; talks to two swmm_deque instances through command/status structs.
module swmm_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_valid,
    input  swmm_pkg::job_t         job,
    output logic                   job_pop,
    output swmm_pkg::dq_cmd_t      min_cmd,
    output swmm_pkg::dq_cmd_t      max_cmd,
    input  swmm_pkg::dq_stat_t     min_stat,
    input  swmm_pkg::dq_stat_t     max_stat,
    output logic                   result_valid,
    input  logic                   result_ready,
    output swmm_pkg::result_beat_t result_beat
);

    localparam int PB = swmm_pkg::PEND_BITS;
    localparam int LB = swmm_pkg::LIMIT_BITS;
    localparam int QB = swmm_pkg::POS_BITS;

    swmm_pkg::back_state_t  state_reg, state_next;
    swmm_pkg::job_t         cur_reg;
    logic [PB-1:0]          pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    swmm_pkg::result_beat_t out_beat_reg;

    logic          both_idle, slot_free, more_after_push, more_after_emit, final_point;
    logic [PB-1:0] pend_dec;
    logic [LB-1:0] limit_first, limit_again, limit_sel;
    logic          issue_push, issue_front, issue_clear, out_load;
    logic [QB-1:0] cmd_pos;

    assign both_idle       = !min_stat.busy && !max_stat.busy;
    assign slot_free       = !out_valid_reg || result_ready;
    assign pend_dec        = pend_reg - PB'(1);
    assign more_after_push = (pend_reg > PB'(cur_reg.keep));
    assign more_after_emit = (pend_dec > PB'(cur_reg.keep));
    assign final_point     = cur_reg.last && (pend_dec == '0);
    // distance from the newest sample back to the left edge of the window
    assign limit_first     = LB'(pend_reg) - LB'(1) + LB'(cur_reg.radius);
    assign limit_again     = LB'(pend_reg) - LB'(2) + LB'(cur_reg.radius);
    assign cmd_pos         = (state_reg == swmm_pkg::BK_IDLE) ? job.pos : cur_reg.pos;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swmm_pkg::BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = swmm_pkg::BK_PUSH;
                end
            end
            swmm_pkg::BK_PUSH:
            begin
                if (both_idle)
                begin
                    state_next = more_after_push ? swmm_pkg::BK_FRONT : swmm_pkg::BK_IDLE;
                end
            end
            swmm_pkg::BK_FRONT:
            begin
                if (both_idle && slot_free)
                begin
                    state_next = more_after_emit ? swmm_pkg::BK_FRONT : swmm_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = swmm_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        job_pop     = 1'b0;
        issue_push  = 1'b0;
        issue_front = 1'b0;
        issue_clear = 1'b0;
        out_load    = 1'b0;
        limit_sel   = limit_first;
        pend_next   = pend_reg;
        unique case (state_reg)
            swmm_pkg::BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    issue_push = 1'b1;
                    pend_next  = job.pend;
                end
            end
            swmm_pkg::BK_PUSH:
            begin
                if (both_idle)
                begin
                    if (more_after_push)
                    begin
                        issue_front = 1'b1;
                    end
                    else
                    begin
                        issue_clear = cur_reg.last;
                    end
                end
            end
            swmm_pkg::BK_FRONT:
            begin
                if (both_idle && slot_free)
                begin
                    out_load  = 1'b1;
                    pend_next = pend_dec;
                    limit_sel = limit_again;
                    if (more_after_emit)
                    begin
                        issue_front = 1'b1;
                    end
                    else
                    begin
                        issue_clear = cur_reg.last;
                    end
                end
            end
            default:
            begin
                pend_next = pend_reg;
            end
        endcase
    end

    always_comb
    begin
        min_cmd.push  = issue_push;
        min_cmd.front = issue_front;
        min_cmd.clear = issue_clear;
        min_cmd.value = job.value;
        min_cmd.pos   = cmd_pos;
        min_cmd.limit = limit_sel;
        // max deque runs as a min deque over inverted values
        max_cmd.push  = issue_push;
        max_cmd.front = issue_front;
        max_cmd.clear = issue_clear;
        max_cmd.value = ~job.value;
        max_cmd.pos   = cmd_pos;
        max_cmd.limit = limit_sel;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_beat  = out_beat_reg;

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            cur_reg <= job;
        end
        if (out_load)
        begin
            out_beat_reg.lower_value    <= min_stat.value;
            out_beat_reg.lower_position <= min_stat.pos;
            out_beat_reg.upper_value    <= ~max_stat.value;
            out_beat_reg.upper_position <= max_stat.pos;
            out_beat_reg.final_result   <= final_point;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swmm_pkg::BK_IDLE;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/sliding_window_min_max_with_index_unit.sv
`timescale 1ns / 1ps
// sliding_window_min_max_with_index_unit.sv: top level of the streaming min/max envelope.
// Uses swmm_pkg, swmm_front, swmm_queue, swmm_deque (with swmm_ram), swmm_back.
//
//  Channel  Dir  Handshake                    Beat
//  sample   in   sample_valid / sample_ready  swmm_pkg::sample_beat_t
//  result   out  result_valid / result_ready  swmm_pkg::result_beat_t
//  radius   in   radius_wr_en, no wait        6-bit half width r
//
// Back end: the work for a sample releasing k envelope points grows with k, with P, the
//   larger back-pop count of the two deques, and with E, the larger head expiry count for
//   each point; the single read port and registered read of each deque RAM set this, one
//   entry examined per cycle.
// Reset: asynchronous, active low; deques come up empty through their counts, no clearing pass.
// Stalls: a two-beat queue parts the front from the deque sequencer, and the result register
//   lets the next sample be worked while a finished beat waits on result_ready.
`include "sliding_window_min_max_with_index_unit_assert.svh"
module sliding_window_min_max_with_index_unit #(
    parameter int DEQUE_DEPTH = 128
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             radius_wr_en,
    input  logic [swmm_pkg::RADIUS_BITS-1:0] radius_wr_data,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  swmm_pkg::sample_beat_t           sample_beat,
    output logic                             result_valid,
    input  logic                             result_ready,
    output swmm_pkg::result_beat_t           result_beat
);

    // front -> queue
    swmm_pkg::job_t     job_in;
    logic               job_push;
    logic               job_full;
    // queue -> back
    swmm_pkg::job_t     job_head;
    logic               job_valid;
    logic               job_pop;
    // back <-> deques
    swmm_pkg::dq_cmd_t  min_cmd, max_cmd;
    swmm_pkg::dq_stat_t min_stat, max_stat;

    // Front: takes samples, numbers them and decides how many points each releases.
    swmm_front #(
        .DEQUE_DEPTH (DEQUE_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .radius_wr_en   (radius_wr_en),
        .radius_wr_data (radius_wr_data),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .sample_beat    (sample_beat),
        .job_full       (job_full),
        .job_push       (job_push),
        .job            (job_in)
    );

    swmm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_data  (job_in),
        .full       (job_full),
        .pop        (job_pop),
        .head_valid (job_valid),
        .head       (job_head)
    );

    // Back: pushes into both deques, then reads one window head per envelope point.
    swmm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (job_head),
        .job_pop      (job_pop),
        .min_cmd      (min_cmd),
        .max_cmd      (max_cmd),
        .min_stat     (min_stat),
        .max_stat     (max_stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_beat  (result_beat)
    );

    // Two identical deques; the max one holds bit-inverted values.
    swmm_deque #(
        .DEPTH (DEQUE_DEPTH)
    ) u_min_deque (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (min_cmd),
        .stat  (min_stat)
    );

    swmm_deque #(
        .DEPTH (DEQUE_DEPTH)
    ) u_max_deque (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (max_cmd),
        .stat  (max_stat)
    );

    // Commands only reach a deque that has finished its previous operation.
    `SWMM_ASSERT_IMPLY(a_min_cmd_idle, min_cmd.push || min_cmd.front || min_cmd.clear, !min_stat.busy, "min deque commanded while busy")
    `SWMM_ASSERT_IMPLY(a_max_cmd_idle, max_cmd.push || max_cmd.front || max_cmd.clear, !max_stat.busy, "max deque commanded while busy")
    // Both deques see the same sequence of operations.
    `SWMM_ASSERT_IMPLY(a_cmd_lockstep, min_cmd.push || min_cmd.front, (max_cmd.push == min_cmd.push) && (max_cmd.front == min_cmd.front), "deque commands out of step")
    // A head read always leaves the deque busy in the following cycle.
    `SWMM_ASSERT_NEXT(a_front_busy, min_cmd.front, min_stat.busy, "min deque ignored a head read")

endmodule
